[rtl/cpd_pkg.sv]
// Package for the complex 2x2 pyramid downsampler: payload structs, field widths,
// register codes and reset values. No dependencies.
package cpd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int PAIR_W      = SAMPLE_BITS + 1;
   localparam int SUM_W       = SAMPLE_BITS + 2;

   localparam int COLS_W      = 13;
   localparam int ROWS_W      = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_COLUMNS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ROWS    = 1'b1;

   localparam logic [COLS_W-1:0] COLS_RESET = 13'd4096;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 16'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] pixel_re;
      logic signed [SAMPLE_BITS-1:0] pixel_im;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mean_re;
      logic signed [SAMPLE_BITS-1:0] mean_im;
      logic                          frame_last;
   } rsp_type;

endpackage

[rtl/cpd_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
module cpd_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/complex_pyramid_2x2_downsample.sv]
// Top level of the complex 2x2 box-filter pyramid downsampler.
// Depends on cpd_pkg and cpd_ram.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------
//   req     | in        | req_valid / req_ready | req_type: pixel_re, pixel_im
//   rsp     | out       | rsp_valid / rsp_ready | rsp_type: mean_re, mean_im, frame_last
//   csr     | in        | csr_we (no wait)      | csr_index, csr_wdata
//
// Throughput is one source pixel per cycle unless req_ready drops; the limit is the
// single line-buffer access (write on even rows, read on odd rows) made for each pixel pair.
// A result passes stage 1, then the output register, after its odd-row, odd-column pixel.
// Reset is synchronous and clears the counters, held pixel and pipeline valids, and sets the
// size registers to their reset values; the line buffer needs no clearing pass, since each
// entry is written on an even row before the following odd row reads it.
// A stalled rsp item holds in the output register while pixels keep flowing; once
// one more completed pair waits in stage 1 as well, req_ready drops for every
// pixel until the rsp item is taken.
module complex_pyramid_2x2_downsample
   import cpd_pkg::*;
#(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LINE_DEPTH = MAX_COLUMNS / 2;
   localparam int LA_W       = $clog2(LINE_DEPTH);
   localparam int COL_W      = $clog2(MAX_COLUMNS);
   localparam int CNT_W      = $clog2(MAX_COLUMNS + 1);
   localparam int WIDE_W     = (COLS_W > CNT_W) ? COLS_W : CNT_W;

   // Configuration registers
   logic [COLS_W-1:0] cols_ff;
   logic [ROWS_W-1:0] rows_ff;

   // Raster position and the even-column pixel of the current pair
   logic [COL_W-1:0]              column_ff, column_in;
   logic [ROWS_W-1:0]             row_ff, row_in;
   logic signed [SAMPLE_BITS-1:0] held_re_ff, held_im_ff;

   // Stage 1: completed odd-row pair waiting for the line-buffer read
   logic                     s1_valid_ff, s1_last_ff;
   logic signed [PAIR_W-1:0] s1_re_ff, s1_im_ff;

   // Output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                     accept, move;
   logic [WIDE_W-1:0]        cols_wide;
   logic [CNT_W-1:0]         cols_eff, used_cols, col_ext, col_next;
   logic [ROWS_W-1:0]        rows_eff, used_rows;
   logic [ROWS_W:0]          row_next;
   logic                     in_block, odd_col, odd_row, last_pair;
   logic signed [PAIR_W-1:0] pair_re, pair_im, line_re, line_im;
   logic signed [SUM_W-1:0]  sum_re, sum_im;
   logic [LA_W-1:0]          line_addr;
   logic                     line_wr, line_rd;
   logic [2*PAIR_W-1:0]      line_wdata, line_rdata;

   // Handshake: stage 1 drains into the output register whenever that slot frees
   assign move      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Saturate the sizes into their legal ranges
   assign cols_wide = WIDE_W'(cols_ff);
   always_comb begin
      if (cols_wide < WIDE_W'(2)) begin
         cols_eff = CNT_W'(2);
      end else if (cols_wide > WIDE_W'(MAX_COLUMNS)) begin
         cols_eff = CNT_W'(MAX_COLUMNS);
      end else begin
         cols_eff = CNT_W'(cols_wide);
      end
   end
   assign rows_eff  = (rows_ff < ROWS_W'(2)) ? ROWS_W'(2) : rows_ff;
   // Drop a trailing odd column or row from the block area
   assign used_cols = cols_eff & ~CNT_W'(1);
   assign used_rows = rows_eff & ~ROWS_W'(1);

   assign col_ext   = CNT_W'(column_ff);
   assign col_next  = col_ext + CNT_W'(1);
   assign row_next  = {1'b0, row_ff} + (ROWS_W + 1)'(1);
   assign in_block  = (col_ext < used_cols) && (row_ff < used_rows);
   assign odd_col   = column_ff[0];
   assign odd_row   = row_ff[0];
   assign last_pair = (col_ext == used_cols - CNT_W'(1)) &&
                      (row_ff == used_rows - ROWS_W'(1));

   // Horizontal pair sums, exact in one extra bit
   assign pair_re = PAIR_W'(held_re_ff) + PAIR_W'(req_data.pixel_re);
   assign pair_im = PAIR_W'(held_im_ff) + PAIR_W'(req_data.pixel_im);

   // Even rows store the pair sum, odd rows fetch it. Both columns of a pair
   // share one entry, and a row's entries are read only on the next row, so
   // a read never meets a write to the same entry in flight.
   assign line_addr  = LA_W'(column_ff >> 1);
   assign line_wr    = accept && in_block && odd_col && !odd_row;
   assign line_rd    = accept && in_block && odd_col && odd_row;
   assign line_wdata = {pair_im, pair_re};

   cpd_ram #(
      .WIDTH (2 * PAIR_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (line_addr),
      .wr_data (line_wdata),
      .rd_en   (line_rd),
      .rd_addr (line_addr),
      .rd_data (line_rdata)
   );

   // Complete the block: four-pixel sum, then floor divide by four
   assign line_re = line_rdata[PAIR_W-1:0];
   assign line_im = line_rdata[2*PAIR_W-1:PAIR_W];
   assign sum_re  = SUM_W'(line_re) + SUM_W'(s1_re_ff);
   assign sum_im  = SUM_W'(line_im) + SUM_W'(s1_im_ff);

   always_comb begin
      rsp_data_in.mean_re    = sum_re[SUM_W-1:2];
      rsp_data_in.mean_im    = sum_im[SUM_W-1:2];
      rsp_data_in.frame_last = s1_last_ff;
   end

   // Advance the raster position; wrap at the end of a line and of the frame
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (col_next >= cols_eff) begin
         column_in = '0;
         row_in    = (row_next >= {1'b0, rows_eff}) ? '0 : row_next[ROWS_W-1:0];
      end else begin
         column_in = COL_W'(col_next);
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SOURCE_COLUMNS: cols_ff <= csr_wdata[COLS_W-1:0];
            CSR_SOURCE_ROWS:    rows_ff <= csr_wdata[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Position counters and held pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= '0;
         row_ff     <= '0;
         held_re_ff <= '0;
         held_im_ff <= '0;
      end else if (accept) begin
         column_ff <= column_in;
         row_ff    <= row_in;
         if (in_block && !odd_col) begin
            held_re_ff <= req_data.pixel_re;
            held_im_ff <= req_data.pixel_im;
         end
      end
   end

   // Stage 1 valid: load on an odd-row pair, drop once moved on
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (line_rd) begin
         s1_valid_ff <= 1'b1;
      end else if (move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (line_rd) begin
         s1_re_ff   <= pair_re;
         s1_im_ff   <= pair_im;
         s1_last_ff <= last_pair;
      end
   end

   // Output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/cpd_checker.sv]
// Port-level checker for the complex 2x2 pyramid downsampler, bound to the top level.
// Depends on cpd_pkg and complex_pyramid_2x2_downsample.
module cpd_checker
   import cpd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled rsp item holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // A waiting req item holds its payload
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req item changed while waiting");

   // Backpressure on req only when the output slot is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without a stalled rsp item");

   // A new rsp item follows an accepted req item through stage 1 and the output register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp item appeared without a preceding req item");

endmodule

bind complex_pyramid_2x2_downsample cpd_checker u_cpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
